// ===== rtl/jsu_pkg.sv =====
`timescale 1ns / 1ps
package jsu_pkg;

   // input item: one text byte or the end-of-text mark
   typedef struct packed {
      logic       req_type;
      logic [7:0] in_byte;
   } req_payload_type;

   // one result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       string_done;
      logic [2:0] error_code;
      logic       last;
   } rsp_payload_type;

   // error codes
   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_NO_QUOTE    = 3'd1;
   localparam logic [2:0] ERR_UNTERM_STR  = 3'd2;
   localparam logic [2:0] ERR_UNTERM_ESC  = 3'd3;
   localparam logic [2:0] ERR_BAD_ESC     = 3'd4;
   localparam logic [2:0] ERR_TRUNC_HEX   = 3'd5;
   localparam logic [2:0] ERR_BAD_HEX     = 3'd6;

   // request kinds
   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_END  = 1'b1;

   // characters of interest
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_U      = 8'h75;

   // decoder modes
   typedef enum logic [3:0] {
      MODE_IDLE       = 4'd0,
      MODE_STR        = 4'd1,
      MODE_ESC        = 4'd2,
      MODE_HEX        = 4'd3,
      MODE_AFTER_HIGH = 4'd4,
      MODE_HIGH_BS    = 4'd5,
      MODE_HEX2       = 4'd6,
      MODE_FINISHED   = 4'd7,
      MODE_DROP       = 4'd8
   } mode_type;

   // what follows the code points of a command
   typedef enum logic [1:0] {
      TAIL_NONE  = 2'd0,
      TAIL_BYTE  = 2'd1,
      TAIL_DONE  = 2'd2,
      TAIL_ERROR = 2'd3
   } tail_type;

   // segment of a command being sent by the back end
   typedef enum logic [1:0] {
      SEG_CP0  = 2'd0,
      SEG_CP1  = 2'd1,
      SEG_TAIL = 2'd2
   } seg_type;

   // command from front to back: up to two code points, then a tail
   typedef struct packed {
      logic        cp0_en;
      logic [20:0] cp0;
      logic        cp1_en;
      logic [15:0] cp1;
      tail_type    tail;
      logic [7:0]  tail_byte;
      logic [2:0]  tail_err;
   } cmd_type;

   // number of UTF-8 bytes of a code point
   function automatic logic [2:0] utf8_len(input logic [20:0] cp);
      logic [2:0] len;
      if (cp <= 21'h00007F) begin
         len = 3'd1;
      end else if (cp <= 21'h0007FF) begin
         len = 3'd2;
      end else if (cp <= 21'h00FFFF) begin
         len = 3'd3;
      end else begin
         len = 3'd4;
      end
      return len;
   endfunction

   // one UTF-8 byte of a code point
   function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] idx);
      logic [7:0] b;
      b = 8'h00;
      case (utf8_len(cp))
         3'd1: b = cp[7:0];
         3'd2: begin
            case (idx)
               2'd0:    b = {3'b110, cp[10:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         3'd3: begin
            case (idx)
               2'd0:    b = {4'b1110, cp[15:12]};
               2'd1:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
         default: begin
            case (idx)
               2'd0:    b = {5'b11110, cp[20:18]};
               2'd1:    b = {2'b10, cp[17:12]};
               2'd2:    b = {2'b10, cp[11:6]};
               default: b = {2'b10, cp[5:0]};
            endcase
         end
      endcase
      return b;
   endfunction

   // hex digit: {ok, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         r = {1'b1, b[3:0] + 4'd9};
      end else begin
         r = 5'd0;
      end
      return r;
   endfunction

   // simple escape letter: {hit, byte}
   function automatic logic [8:0] simple_escape(input logic [7:0] b);
      logic [8:0] r;
      case (b)
         8'h22:   r = {1'b1, 8'h22};
         8'h5C:   r = {1'b1, 8'h5C};
         8'h2F:   r = {1'b1, 8'h2F};
         8'h62:   r = {1'b1, 8'h08};
         8'h66:   r = {1'b1, 8'h0C};
         8'h6E:   r = {1'b1, 8'h0A};
         8'h72:   r = {1'b1, 8'h0D};
         8'h74:   r = {1'b1, 8'h09};
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic logic is_high(input logic [15:0] v);
      return (v >= 16'hD800) && (v <= 16'hDBFF);
   endfunction

   function automatic logic is_low(input logic [15:0] v);
      return (v >= 16'hDC00) && (v <= 16'hDFFF);
   endfunction

endpackage

// ===== rtl/jsu_front.sv =====
`timescale 1ns / 1ps
module jsu_front
   import jsu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_fire,
   input  req_payload_type req_data,
   output logic            cmd_push,
   output cmd_type         cmd
);

   mode_type    mode_ff, mode_in;
   logic [15:0] accum_ff, accum_in;
   logic [1:0]  count_ff, count_in;
   logic [15:0] high_ff, high_in;

   logic [4:0]  hex_d;
   logic [8:0]  esc_d;
   logic [15:0] accum_new;
   logic [7:0]  b;

   // hold decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         accum_ff <= 16'd0;
         count_ff <= 2'd0;
         high_ff  <= 16'd0;
      end else begin
         mode_ff  <= mode_in;
         accum_ff <= accum_in;
         count_ff <= count_in;
         high_ff  <= high_in;
      end
   end

   assign b         = req_data.in_byte;
   assign hex_d     = hex_digit(b);
   assign esc_d     = simple_escape(b);
   assign accum_new = {accum_ff[11:0], hex_d[3:0]};

   // classify the byte and build a command
   always_comb begin
      mode_in  = mode_ff;
      accum_in = accum_ff;
      count_in = count_ff;
      high_in  = high_ff;
      cmd      = '0;
      cmd.tail = TAIL_NONE;
      if (req_fire) begin
         if (req_data.req_type == REQ_END) begin
            unique case (mode_ff) inside
               MODE_IDLE: begin
                  cmd.tail = TAIL_ERROR; cmd.tail_err = ERR_NO_QUOTE;
               end
               MODE_STR, MODE_AFTER_HIGH: begin
                  cmd.tail = TAIL_ERROR; cmd.tail_err = ERR_UNTERM_STR;
               end
               MODE_ESC, MODE_HIGH_BS: begin
                  cmd.tail = TAIL_ERROR; cmd.tail_err = ERR_UNTERM_ESC;
               end
               MODE_HEX, MODE_HEX2: begin
                  cmd.tail = TAIL_ERROR; cmd.tail_err = ERR_TRUNC_HEX;
               end
               default: ;
            endcase
            mode_in  = MODE_IDLE;
            accum_in = 16'd0;
            count_in = 2'd0;
            high_in  = 16'd0;
         end else begin
            unique case (mode_ff) inside
               MODE_IDLE: begin
                  if (b == CH_QUOTE) begin
                     mode_in = MODE_STR;
                  end else begin
                     cmd.tail = TAIL_ERROR; cmd.tail_err = ERR_NO_QUOTE;
                  end
               end
               MODE_STR: begin
                  if (b == CH_QUOTE) begin
                     cmd.tail = TAIL_DONE;
                     mode_in  = MODE_FINISHED;
                  end else if (b == CH_BSLASH) begin
                     mode_in = MODE_ESC;
                  end else begin
                     cmd.tail = TAIL_BYTE; cmd.tail_byte = b;
                  end
               end
               MODE_ESC: begin
                  if (b == CH_U) begin
                     accum_in = 16'd0; count_in = 2'd0; mode_in = MODE_HEX;
                  end else if (esc_d[8]) begin
                     cmd.tail = TAIL_BYTE; cmd.tail_byte = esc_d[7:0];
                     mode_in  = MODE_STR;
                  end else begin
                     cmd.tail = TAIL_ERROR; cmd.tail_err = ERR_BAD_ESC;
                  end
               end
               MODE_HEX, MODE_HEX2: begin
                  if (!hex_d[4]) begin
                     cmd.tail = TAIL_ERROR; cmd.tail_err = ERR_BAD_HEX;
                  end else begin
                     accum_in = accum_new;
                     if (count_ff != 2'd3) begin
                        count_in = count_ff + 2'd1;
                     end else begin
                        count_in = 2'd0;
                        if (mode_ff == MODE_HEX2) begin
                           cmd.cp0_en = 1'b1;
                           high_in    = 16'd0;
                           if (is_low(accum_new)) begin
                              // join the surrogate pair
                              cmd.cp0 = 21'h10000 + {1'b0, high_ff[9:0], accum_new[9:0]};
                              mode_in = MODE_STR;
                           end else begin
                              // flush the lone high, then take the new value
                              cmd.cp0 = {5'd0, high_ff};
                              if (is_high(accum_new)) begin
                                 high_in = accum_new;
                                 mode_in = MODE_AFTER_HIGH;
                              end else begin
                                 cmd.cp1_en = 1'b1;
                                 cmd.cp1    = accum_new;
                                 mode_in    = MODE_STR;
                              end
                           end
                        end else if (is_high(accum_new)) begin
                           high_in = accum_new;
                           mode_in = MODE_AFTER_HIGH;
                        end else begin
                           cmd.cp0_en = 1'b1;
                           cmd.cp0    = {5'd0, accum_new};
                           mode_in    = MODE_STR;
                        end
                     end
                  end
               end
               MODE_AFTER_HIGH: begin
                  if (b == CH_BSLASH) begin
                     mode_in = MODE_HIGH_BS;
                  end else begin
                     cmd.cp0_en = 1'b1;
                     cmd.cp0    = {5'd0, high_ff};
                     high_in    = 16'd0;
                     if (b == CH_QUOTE) begin
                        cmd.tail = TAIL_DONE;
                        mode_in  = MODE_FINISHED;
                     end else begin
                        cmd.tail = TAIL_BYTE; cmd.tail_byte = b;
                        mode_in  = MODE_STR;
                     end
                  end
               end
               MODE_HIGH_BS: begin
                  if (b == CH_U) begin
                     accum_in = 16'd0; count_in = 2'd0; mode_in = MODE_HEX2;
                  end else if (esc_d[8]) begin
                     cmd.cp0_en    = 1'b1;
                     cmd.cp0       = {5'd0, high_ff};
                     high_in       = 16'd0;
                     cmd.tail      = TAIL_BYTE;
                     cmd.tail_byte = esc_d[7:0];
                     mode_in       = MODE_STR;
                  end else begin
                     cmd.tail = TAIL_ERROR; cmd.tail_err = ERR_BAD_ESC;
                  end
               end
               default: ;
            endcase
            // drop everything after an error
            if (cmd.tail == TAIL_ERROR) begin
               mode_in  = MODE_DROP;
               accum_in = 16'd0;
               count_in = 2'd0;
               high_in  = 16'd0;
            end
         end
      end
   end

   assign cmd_push = cmd.cp0_en || cmd.cp1_en || (cmd.tail != TAIL_NONE);

endmodule

// ===== rtl/jsu_cmd_fifo.sv =====
`timescale 1ns / 1ps
module jsu_cmd_fifo
   import jsu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type head,
   output logic    empty,
   output logic    full
);

   cmd_type    mem_ff [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;

   // advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // store commands
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign empty = (count_ff == 2'd0);
   assign full  = (count_ff == 2'd2);

endmodule

// ===== rtl/jsu_back.sv =====
`timescale 1ns / 1ps
module jsu_back
   import jsu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         head,
   input  logic            head_valid,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   seg_type         seg_ff, seg_in;
   logic [1:0]      idx_ff, idx_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   seg_type         cur;
   logic [20:0]     cur_cp;
   logic [2:0]      cur_len;
   logic            seg_end;
   logic            load;
   rsp_payload_type res;

   assign load = head_valid && (!rsp_valid_ff || !rsp_stall);

   // pick the segment to send and form its result
   always_comb begin
      if (seg_ff == SEG_CP0 && head.cp0_en) begin
         cur = SEG_CP0;
      end else if (seg_ff != SEG_TAIL && head.cp1_en) begin
         cur = SEG_CP1;
      end else begin
         cur = SEG_TAIL;
      end
      cur_cp  = (cur == SEG_CP1) ? {5'd0, head.cp1} : head.cp0;
      cur_len = utf8_len(cur_cp);
      seg_end = ({1'b0, idx_ff} == (cur_len - 3'd1));
      res     = '0;
      unique case (cur)
         SEG_CP0: begin
            res.out_byte   = utf8_byte(cur_cp, idx_ff);
            res.byte_valid = 1'b1;
            res.last       = seg_end && !head.cp1_en && (head.tail == TAIL_NONE);
         end
         SEG_CP1: begin
            res.out_byte   = utf8_byte(cur_cp, idx_ff);
            res.byte_valid = 1'b1;
            res.last       = seg_end && (head.tail == TAIL_NONE);
         end
         default: begin
            unique case (head.tail)
               TAIL_BYTE: begin
                  res.out_byte   = head.tail_byte;
                  res.byte_valid = 1'b1;
               end
               TAIL_DONE:  res.string_done = 1'b1;
               TAIL_ERROR: res.error_code  = head.tail_err;
               default: ;
            endcase
            res.last = 1'b1;
         end
      endcase
   end

   // advance the segment pointer
   always_comb begin
      seg_in       = seg_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
         if (res.last) begin
            seg_in = SEG_CP0;
            idx_in = 2'd0;
         end else if (!seg_end) begin
            idx_in = idx_ff + 2'd1;
         end else begin
            seg_in = (cur == SEG_CP0) ? SEG_CP1 : SEG_TAIL;
            idx_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_ff       <= SEG_CP0;
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seg_ff       <= seg_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold the result until transfer
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign pop       = load && res.last;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/json_string_unescape_utf8_unit.sv =====
`timescale 1ns / 1ps
// JSON string unescape to UTF-8.
// Input channel (req_): one item per transfer, either a text byte of a quoted
// string starting at the opening quote, or the end-of-text mark. Output
// channel (rsp_): the result items, one per transfer, each with out_byte,
// byte_valid, string_done, error_code and a last flag on the final result of
// each input item. Items that cause no result (quotes entering the string,
// backslashes, hex digits before the fourth, ignored bytes) give none.
// Throughput: one input byte per cycle while each byte gives at most one
// result and rsp_stall is low. A byte may give several results, sent one per
// transfer (up to six for a flushed high surrogate plus a 3-byte code point);
// the two-entry command queue between the classifier and the UTF-8 serializer
// absorbs that, and req_stall rises only when the queue is full.
// With the output side free, the first result of an item is registered in
// the queue and then in the output register before it appears on rsp_.
// Reset (synchronous) returns the decoder to idle, awaiting an opening quote,
// and empties the queue and the output register. While rsp_stall is high the
// output register holds its result; the queue fills and then stalls input.
module json_string_unescape_utf8_unit
   import jsu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   logic    req_fire;
   logic    cmd_push;
   cmd_type cmd;
   cmd_type head;
   logic    fifo_empty;
   logic    fifo_full;
   logic    cmd_pop;

   assign req_stall = fifo_full;
   assign req_fire  = req_valid && !fifo_full;

   jsu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_data (req_data),
      .cmd_push (cmd_push),
      .cmd      (cmd)
   );

   jsu_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd),
      .pop       (cmd_pop),
      .head      (head),
      .empty     (fifo_empty),
      .full      (fifo_full)
   );

   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (!fifo_empty),
      .pop        (cmd_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

   // never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      fifo_full |-> !cmd_push)
      else $error("command pushed into full queue");

   // never pop an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !fifo_empty)
      else $error("command popped from empty queue");

   // done and error results close their input item and carry no byte
   a_term_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.string_done || (rsp_data.error_code != ERR_NONE)))
      |-> (rsp_data.last && !rsp_data.byte_valid))
      else $error("done or error result not last or carries a byte");

   // output is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule
